>>> design/command_sequence_prefix_matcher_top_macros.svh
// assertion macros for the prefix matcher
`ifndef COMMAND_SEQUENCE_PREFIX_MATCHER_TOP_MACROS_SVH
`define COMMAND_SEQUENCE_PREFIX_MATCHER_TOP_MACROS_SVH

// same-cycle implication
`define CSPM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/cspm_pkg.sv
`default_nettype none
package cspm_pkg;

   localparam int PATTERN_SLOTS   = 8;
   localparam int NUM_PATTERNS_DEF = 8;
   localparam int MAX_LEN         = 10;
   localparam int MAX_SYMS        = 10;
   localparam int SYM_W           = 3;
   localparam int LEN_W           = 4;
   localparam int DELAY_W         = 16;
   localparam int COUNT_W         = 4;
   localparam int IDX_W           = 3;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = DELAY_W + MAX_SYMS * SYM_W + LEN_W;
   localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(11);

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic [DELAY_W-1:0]                delay;
      logic [MAX_SYMS-1:0][SYM_W-1:0]    syms;
      logic [LEN_W-1:0]                  len;
   } pattern_type;

   typedef struct packed {
      logic             func;
      logic [SYM_W-1:0] command;
   } req_type;

   typedef struct packed {
      logic [PATTERN_SLOTS-1:0] match_mask;
      logic                     selected_valid;
      logic [IDX_W-1:0]         selected_index;
      logic [DELAY_W-1:0]       selected_delay;
      logic [COUNT_W-1:0]       input_count;
   } rsp_type;

   typedef struct packed {
      logic               chosen_valid;
      logic [IDX_W-1:0]   chosen_index;
      logic [DELAY_W-1:0] chosen_delay;
      logic [COUNT_W-1:0] entered_count;
   } state_type;

endpackage
`default_nettype wire

>>> design/cspm_cfg.sv
`default_nettype none
module cspm_cfg #(
   parameter int NUM_PATTERNS = cspm_pkg::NUM_PATTERNS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [cspm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [cspm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output cspm_pkg::pattern_type [NUM_PATTERNS-1:0]   patterns
);

   cspm_pkg::pattern_type [NUM_PATTERNS-1:0] pattern_ff;

   for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_entry
      always_ff @(posedge clock) begin
         if (reset) begin
            pattern_ff[i] <= '0;
         end else if (csr_wen && csr_addr == cspm_pkg::CSR_ADDR_W'(i)) begin
            pattern_ff[i] <= cspm_pkg::pattern_type'(csr_wdata);
         end
      end
   end

   assign patterns = pattern_ff;

endmodule
`default_nettype wire

>>> design/cspm_match.sv
`default_nettype none
module cspm_match #(
   parameter int NUM_PATTERNS = cspm_pkg::NUM_PATTERNS_DEF
) (
   input  wire cspm_pkg::pattern_type [NUM_PATTERNS-1:0] patterns,
   input  wire logic [NUM_PATTERNS-1:0]                  alive,
   input  wire cspm_pkg::state_type                      state,
   input  wire cspm_pkg::req_type                        req,
   output logic [NUM_PATTERNS-1:0]                       alive_next,
   output cspm_pkg::state_type                           state_next,
   output cspm_pkg::rsp_type                             rsp
);

   logic [NUM_PATTERNS-1:0] hit;
   logic [NUM_PATTERNS-1:0] done;

   always_comb begin
      logic [cspm_pkg::LEN_W-1:0]   len;
      logic [cspm_pkg::SYM_W-1:0]   sym;
      logic [cspm_pkg::COUNT_W-1:0] pos;
      logic                         len_ok;
      logic                         pos_ok;
      pos = state.entered_count;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         len    = patterns[i].len;
         len_ok = (len != '0) && (len <= cspm_pkg::LEN_W'(cspm_pkg::MAX_LEN));
         pos_ok = pos < cspm_pkg::COUNT_W'(len);
         sym    = (pos < cspm_pkg::COUNT_W'(cspm_pkg::MAX_SYMS)) ? patterns[i].syms[pos] : '0;
         hit[i]  = alive[i] && len_ok && pos_ok && (sym == req.command);
         done[i] = hit[i] && (cspm_pkg::COUNT_W'(len) == pos + cspm_pkg::COUNT_W'(1));
      end
   end

   always_comb begin
      state_next = state;
      alive_next = hit;
      if (req.func == cspm_pkg::FUNC_CLEAR) begin
         state_next = '0;
         alive_next = '1;
      end else begin
         for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (done[i]) begin
               state_next.chosen_valid = 1'b1;
               state_next.chosen_index = cspm_pkg::IDX_W'(i);
               state_next.chosen_delay = patterns[i].delay;
            end
         end
         state_next.entered_count = (state.entered_count >= cspm_pkg::COUNT_SAT) ?
            cspm_pkg::COUNT_SAT : state.entered_count + cspm_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      rsp.match_mask     = (req.func == cspm_pkg::FUNC_CLEAR) ?
                           '0 : cspm_pkg::PATTERN_SLOTS'(hit);
      rsp.selected_valid = state_next.chosen_valid;
      rsp.selected_index = state_next.chosen_index;
      rsp.selected_delay = state_next.chosen_delay;
      rsp.input_count    = state_next.entered_count;
   end

endmodule
`default_nettype wire

>>> design/command_sequence_prefix_matcher_top.sv
// pipeline: an accepted request passes the request register and then the response register (2 regs)
// throughput: one request per cycle while the response side does not stall, set by the single compare
//   stage between the request register and the response register
// reset (synchronous, active high): pattern registers cleared, all patterns live,
//   count and selection cleared, both pipeline stages empty
`default_nettype none
module command_sequence_prefix_matcher_top #(
   parameter int NUM_PATTERNS = cspm_pkg::NUM_PATTERNS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire cspm_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output cspm_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_wen,
   input  wire logic [cspm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [cspm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cspm_pkg::pattern_type [NUM_PATTERNS-1:0] patterns;

   logic                    req_valid_ff;
   cspm_pkg::req_type       req_ff;
   logic                    rsp_valid_ff;
   cspm_pkg::rsp_type       rsp_ff;
   logic [NUM_PATTERNS-1:0] alive_ff;
   cspm_pkg::state_type     state_ff;

   logic [NUM_PATTERNS-1:0] alive_in;
   cspm_pkg::state_type     state_in;
   cspm_pkg::rsp_type       rsp_in;
   logic                    advance;

   cspm_cfg #(.NUM_PATTERNS(NUM_PATTERNS)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .patterns  (patterns)
   );

   cspm_match #(.NUM_PATTERNS(NUM_PATTERNS)) u_match (
      .patterns   (patterns),
      .alive      (alive_ff),
      .state      (state_ff),
      .req        (req_ff),
      .alive_next (alive_in),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         alive_ff     <= '1;
         state_ff     <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            alive_ff     <= alive_in;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> design/cspm_checker.sv
`default_nettype none
`include "command_sequence_prefix_matcher_top_macros.svh"
module cspm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire cspm_pkg::rsp_type rsp_data
);

   `CSPM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response after reset")

   `CSPM_ASSERT_SAME(a_none_zero, clock, reset, rsp_valid && !rsp_data.selected_valid,
      rsp_data.selected_index == '0 && rsp_data.selected_delay == '0, "stale selection")

   `CSPM_ASSERT_SAME(a_clear_shape, clock, reset, rsp_valid && rsp_data.input_count == '0,
      rsp_data.match_mask == '0 && !rsp_data.selected_valid, "clear response not empty")

   `CSPM_ASSERT_SAME(a_long_dead, clock, reset,
      rsp_valid && rsp_data.input_count > cspm_pkg::COUNT_W'(cspm_pkg::MAX_LEN),
      rsp_data.match_mask == '0 && rsp_data.input_count == cspm_pkg::COUNT_SAT,
      "long entry still matching")

   `CSPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind command_sequence_prefix_matcher_top cspm_checker u_cspm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import cspm_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   command_sequence_prefix_matcher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // shadow of the pattern table and the matcher state
   pattern_type              pattern_regs [PATTERN_SLOTS] = '{default: '0};
   logic [PATTERN_SLOTS-1:0] live_mask   = '1;
   logic [COUNT_W-1:0]       entry_count = '0;
   logic                     sel_valid   = 1'b0;
   logic [IDX_W-1:0]         sel_index   = '0;
   logic [DELAY_W-1:0]       sel_delay   = '0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   bit req_busy       = 1'b0;
   int req_gap        = 0;
   int rsp_wait       = 0;
   int hold_left      = 0;
   bit sender_quiet   = 1'b0;
   bit receiver_quiet = 1'b0;
   int mismatches     = 0;
   int rsp_count      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic rsp_type match_command(req_type r);
      rsp_type                  resp;
      logic [PATTERN_SLOTS-1:0] still;
      int                       pos;
      int                       plen;
      still = '0;
      if (r.func == FUNC_CLEAR) begin
         live_mask   = '1;
         entry_count = '0;
         sel_valid   = 1'b0;
         sel_index   = '0;
         sel_delay   = '0;
      end else begin
         pos = int'(entry_count);
         for (int i = 0; i < PATTERN_SLOTS; i++) begin
            plen = int'(pattern_regs[i].len);
            if (live_mask[i] && plen != 0 && plen <= MAX_LEN && pos < plen
                  && pattern_regs[i].syms[pos] == r.command) begin
               still[i] = 1'b1;
               if (pos + 1 == plen) begin
                  sel_valid = 1'b1;
                  sel_index = IDX_W'(i);
                  sel_delay = pattern_regs[i].delay;
               end
            end
         end
         live_mask   = still;
         entry_count = (pos + 1 > int'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(pos + 1);
      end
      resp.match_mask     = still;
      resp.selected_valid = sel_valid;
      resp.selected_index = sel_index;
      resp.selected_delay = sel_delay;
      resp.input_count    = entry_count;
      return resp;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_busy = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin : watch_ports
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(match_command(req_data));
            req_busy = 1'b0;
            req_gap  = sender_quiet ? 0 : int'($urandom_range(0, 15));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            rsp_wait = receiver_quiet ? 0 : int'($urandom_range(0, 15));
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", longint'(rsp_data), 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.match_mask != want.match_mask)
                  report_mismatch("match_mask", rsp_data.match_mask, want.match_mask);
               if (rsp_data.selected_valid != want.selected_valid)
                  report_mismatch("selected_valid", rsp_data.selected_valid,
                                  want.selected_valid);
               if (rsp_data.selected_index != want.selected_index)
                  report_mismatch("selected_index", rsp_data.selected_index,
                                  want.selected_index);
               if (rsp_data.selected_delay != want.selected_delay)
                  report_mismatch("selected_delay", rsp_data.selected_delay,
                                  want.selected_delay);
               if (rsp_data.input_count != want.input_count)
                  report_mismatch("input_count", rsp_data.input_count, want.input_count);
            end
         end
      end
   end

   task automatic write_pattern(int idx, pattern_type p);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_ADDR_W'(idx);
      csr_wdata <= p;
      pattern_regs[idx] = p;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_busy || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_request(logic func, int cmd);
      req_type r;
      r.func    = func;
      r.command = SYM_W'(cmd);
      pending_reqs.push_back(r);
   endfunction

   function automatic pattern_type random_pattern(int alphabet);
      pattern_type p;
      case ($urandom_range(0, 9))
         0: p.len = '0;
         1: p.len = LEN_W'($urandom_range(MAX_LEN + 1, 15));
         default: p.len = LEN_W'($urandom_range(1, MAX_LEN));
      endcase
      for (int k = 0; k < MAX_SYMS; k++) p.syms[k] = SYM_W'($urandom_range(0, alphabet - 1));
      p.delay = DELAY_W'($urandom);
      return p;
   endfunction

   // one command sequence aimed at a configured pattern, or a burst of noise
   function automatic int queue_traffic();
      pattern_type p;
      int          n;
      int          count;
      int          cmd;
      count = 0;
      if ($urandom_range(0, 6) == 0) begin
         n = int'($urandom_range(1, 4));
         for (int k = 0; k < n; k++)
            push_request(1'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
         return n;
      end
      p = pattern_regs[$urandom_range(0, PATTERN_SLOTS - 1)];
      n = (p.len == 0 || p.len > MAX_LEN) ? int'($urandom_range(1, MAX_LEN)) : int'(p.len);
      case ($urandom_range(0, 7))
         0: n = n + int'($urandom_range(1, 3));
         1: n = int'($urandom_range(1, n));
         default: ;
      endcase
      if ($urandom_range(0, 4) != 0) begin
         push_request(FUNC_CLEAR, int'($urandom_range(0, 7)));
         count++;
      end
      for (int k = 0; k < n; k++) begin
         cmd = (k < MAX_LEN) ? int'(p.syms[k]) : int'($urandom_range(0, 7));
         if ($urandom_range(0, 15) == 0) cmd = int'($urandom_range(0, 7));
         push_request(FUNC_ADD, cmd);
      end
      return count + n;
   endfunction

   initial begin : stimulus
      pattern_type p;
      int          alphabet;
      int          queued;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: short, long, tie, unused and out-of-range lengths
      p = '0; p.len = LEN_W'(1); p.delay = '0;
      write_pattern(0, p);
      p = '0; p.len = LEN_W'(MAX_LEN); p.syms = '1; p.delay = '1;
      write_pattern(1, p);
      p = '0; p.len = LEN_W'(3);
      p.syms[0] = SYM_W'(1); p.syms[1] = SYM_W'(2); p.syms[2] = SYM_W'(3);
      p.delay = 16'h1234;
      write_pattern(2, p);
      p.delay = 16'h5678;
      write_pattern(3, p);
      p = '0; p.syms = '1;
      write_pattern(4, p);
      p = '0; p.len = LEN_W'(MAX_LEN + 1);
      write_pattern(5, p);
      p = '1;
      write_pattern(6, p);
      p = '0; p.len = LEN_W'(2); p.syms[0] = SYM_W'(7); p.syms[1] = SYM_W'(7);
      p.delay = 16'habcd;
      write_pattern(7, p);

      push_request(FUNC_ADD, 0);
      push_request(FUNC_ADD, 0);
      push_request(FUNC_CLEAR, 5);
      for (int k = 1; k <= 6; k++) push_request(FUNC_ADD, k);
      push_request(FUNC_CLEAR, 0);
      for (int k = 0; k < 12; k++) push_request(FUNC_ADD, 7);
      push_request(FUNC_CLEAR, 7);
      wait_idle();

      for (int ph = 0; ph < 9; ph++) begin
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         alphabet       = ($urandom_range(0, 1) != 0) ? 2 : 8;
         for (int i = 0; i < PATTERN_SLOTS; i++) begin
            case (ph)
               0: p = '1;
               1: p = '0;
               2: begin
                  p = random_pattern(8);
                  p.len = LEN_W'(MAX_LEN);
                  if (i > 0) p.syms = pattern_regs[0].syms;
               end
               default: p = random_pattern(alphabet);
            endcase
            write_pattern(i, p);
         end
         if (ph == 4) begin
            sender_quiet = 1'b1;
            @(negedge clock);
            hold_left <= 300;
         end
         queued = 0;
         while (queued < 200) queued += queue_traffic();
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
